@@ rtl/core/scaled_decimal_to_float32_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the scaled decimal to float32 block
// Shared wrappers for the concurrent checks.
// ---------------------------------------------------------------------------
`ifndef SCALED_DECIMAL_TO_FLOAT32_MACROS_SVH
`define SCALED_DECIMAL_TO_FLOAT32_MACROS_SVH

// same-cycle implication
`define SDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sdf_pkg.sv @@
// ---------------------------------------------------------------------------
// sdf_pkg
// Types, constants and power-of-ten tables for the decimal to float32 pipe.
// ---------------------------------------------------------------------------
package sdf_pkg;

    localparam int unsigned MagW    = 96;
    localparam int unsigned RemW    = MagW + 1;
    localparam int unsigned LeadW   = 7;
    localparam int unsigned ScaleW  = 8;
    localparam int unsigned ExpW    = 9;
    localparam int unsigned QuoW    = 26;
    localparam int unsigned MaxScale = 28;
    localparam int unsigned TabIdxW = 5;
    localparam logic [ExpW-1:0] Bias = 9'd127;

    typedef logic [MagW-1:0]  t_dn_tab [0:MaxScale];
    typedef logic [LeadW-1:0] t_k_tab  [0:MaxScale];

    typedef struct packed {
        logic [MagW-1:0]   mant;
        logic [ScaleW-1:0] scale;
        logic              neg;
    } t_in;

    typedef struct packed {
        logic [MagW-1:0]  mant;
        logic [LeadW-1:0] lead;
        logic [TabIdxW-1:0] idx;
        logic             neg;
        logic             bad;
        logic             zero;
    } t_lead;

    typedef struct packed {
        logic [RemW-1:0]       rem;
        logic [MagW-1:0]       dn;
        logic [QuoW-1:0]       quo;
        logic signed [ExpW-1:0] expo;
        logic                  neg;
        logic                  bad;
        logic                  zero;
    } t_div;

    typedef struct packed {
        logic [31:0] float_bits;
        logic        bad_scale;
    } t_res;

    function automatic t_dn_tab f_build_dn();
        t_dn_tab         tab;
        logic [MagW-1:0] d;
        int              k;
        d = MagW'(1);
        for (int s = 0; s <= int'(MaxScale); s++) begin
            k = 0;
            for (int b = 0; b < int'(MagW); b++) begin
                if (d[b]) k = b;
            end
            tab[s] = d << (int'(MagW) - 1 - k);
            d = MagW'(d * MagW'(10));
        end
        return tab;
    endfunction

    function automatic t_k_tab f_build_k();
        t_k_tab          tab;
        logic [MagW-1:0] d;
        int              k;
        d = MagW'(1);
        for (int s = 0; s <= int'(MaxScale); s++) begin
            k = 0;
            for (int b = 0; b < int'(MagW); b++) begin
                if (d[b]) k = b;
            end
            tab[s] = LeadW'(k);
            d = MagW'(d * MagW'(10));
        end
        return tab;
    endfunction

    localparam t_dn_tab DnTab = f_build_dn();
    localparam t_k_tab  KTab  = f_build_k();

endpackage

@@ rtl/core/sdf_ifs.sv @@
// ---------------------------------------------------------------------------
// sdf interfaces
// Valid/ready channels for decimal requests and float results.
// ---------------------------------------------------------------------------
interface sdf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] mant_low;
    logic [31:0] mant_mid;
    logic [31:0] mant_high;
    logic [7:0]  scale;
    logic        negative;

    modport source (output valid, mant_low, mant_mid, mant_high, scale, negative,
                    input ready);
    modport sink   (input valid, mant_low, mant_mid, mant_high, scale, negative,
                    output ready);
endinterface

interface sdf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;
    logic        bad_scale;

    modport source (output valid, float_bits, bad_scale, input ready);
    modport sink   (input valid, float_bits, bad_scale, output ready);
endinterface

@@ rtl/core/sdf_norm.sv @@
// ---------------------------------------------------------------------------
// sdf_norm
// Two stages: leading-one search, then normalizing shift and divisor lookup.
// ---------------------------------------------------------------------------
module sdf_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  sdf_pkg::t_in  i_data,
    output logic          o_vld,
    input  logic          i_rdy,
    output sdf_pkg::t_div o_data
);

    logic           r_vld1, r_vld2;
    sdf_pkg::t_lead r_s1, n_s1;
    sdf_pkg::t_div  r_s2, n_s2;
    logic           w_en1, w_en2;

    assign w_en2 = !r_vld2 || i_rdy;
    assign w_en1 = !r_vld1 || w_en2;
    assign o_rdy = w_en1;

    always_comb begin
        n_s1      = '0;
        n_s1.mant = i_data.mant;
        n_s1.neg  = i_data.neg;
        n_s1.bad  = (i_data.scale > sdf_pkg::ScaleW'(sdf_pkg::MaxScale));
        n_s1.zero = (i_data.mant == '0);
        n_s1.idx  = n_s1.bad ? '0 : i_data.scale[sdf_pkg::TabIdxW-1:0];
        for (int b = 0; b < int'(sdf_pkg::MagW); b++) begin
            if (i_data.mant[b]) n_s1.lead = sdf_pkg::LeadW'(b);
        end
    end

    always_comb begin
        n_s2      = '0;
        n_s2.rem  = {1'b0, r_s1.mant << (sdf_pkg::LeadW'(sdf_pkg::MagW - 1) - r_s1.lead)};
        n_s2.dn   = sdf_pkg::DnTab[r_s1.idx];
        n_s2.expo = $signed({2'b00, r_s1.lead}) - $signed({2'b00, sdf_pkg::KTab[r_s1.idx]});
        n_s2.neg  = r_s1.neg;
        n_s2.bad  = r_s1.bad;
        n_s2.zero = r_s1.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (w_en1) r_vld1 <= i_vld;
            if (w_en2) r_vld2 <= r_vld1;
        end
        if (w_en1) r_s1 <= n_s1;
        if (w_en2) r_s2 <= n_s2;
    end

    assign o_vld  = r_vld2;
    assign o_data = r_s2;

endmodule

@@ rtl/core/sdf_div_step.sv @@
// ---------------------------------------------------------------------------
// sdf_div_step
// One restoring division step: one quotient bit per register stage.
// ---------------------------------------------------------------------------
module sdf_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  sdf_pkg::t_div i_data,
    output logic          o_vld,
    input  logic          i_rdy,
    output sdf_pkg::t_div o_data
);

    logic                        r_vld;
    sdf_pkg::t_div               r_d, n_d;
    logic                        w_en, w_ge;
    logic [sdf_pkg::RemW-1:0]    w_diff, w_sel;

    assign w_en  = !r_vld || i_rdy;
    assign o_rdy = w_en;

    always_comb begin
        w_diff = i_data.rem - {1'b0, i_data.dn};
        w_ge   = (i_data.rem >= {1'b0, i_data.dn});
        w_sel  = w_ge ? w_diff : i_data.rem;
        n_d     = i_data;
        n_d.rem = {w_sel[sdf_pkg::RemW-2:0], 1'b0};
        n_d.quo = {i_data.quo[sdf_pkg::QuoW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_vld;
        end
        if (w_en) r_d <= n_d;
    end

    assign o_vld  = r_vld;
    assign o_data = r_d;

endmodule

@@ rtl/core/sdf_round.sv @@
// ---------------------------------------------------------------------------
// sdf_round
// Round to nearest even, pack the float and hold it in the output register.
// ---------------------------------------------------------------------------
module sdf_round (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  sdf_pkg::t_div i_data,
    output logic          o_vld,
    input  logic          i_rdy,
    output sdf_pkg::t_res o_data
);

    logic                       r_vld;
    sdf_pkg::t_res              r_res, n_res;
    logic                       w_en;
    logic [22:0]                w_frac;
    logic                       w_guard, w_sticky, w_up;
    logic [sdf_pkg::ExpW-1:0]   w_biased;
    logic [30:0]                w_mag;

    assign w_en  = !r_vld || i_rdy;
    assign o_rdy = w_en;

    always_comb begin
        if (i_data.quo[sdf_pkg::QuoW-1]) begin
            w_frac   = i_data.quo[24:2];
            w_guard  = i_data.quo[1];
            w_sticky = i_data.quo[0] || (i_data.rem != '0);
            w_biased = i_data.expo + sdf_pkg::Bias;
        end else begin
            w_frac   = i_data.quo[23:1];
            w_guard  = i_data.quo[0];
            w_sticky = (i_data.rem != '0);
            w_biased = i_data.expo + sdf_pkg::Bias - sdf_pkg::ExpW'(1);
        end
        w_up  = w_guard && (w_sticky || w_frac[0]);
        w_mag = {w_biased[7:0], w_frac} + 31'(w_up);
        n_res.bad_scale = i_data.bad;
        if (i_data.bad || i_data.zero) begin
            n_res.float_bits = {i_data.neg, 31'd0};
        end else begin
            n_res.float_bits = {i_data.neg, w_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_vld;
        end
        if (w_en) r_res <= n_res;
    end

    assign o_vld  = r_vld;
    assign o_data = r_res;

endmodule

@@ rtl/core/scaled_decimal_to_float32.sv @@
// ---------------------------------------------------------------------------
// scaled_decimal_to_float32
// Converts sign * M / 10^scale (96-bit M) to IEEE-754 single precision,
// round to nearest even, through a fully pipelined long division.
// ---------------------------------------------------------------------------
//  channel | dir | fields
//  i_req   | in  | mant_low, mant_mid, mant_high, scale, negative
//  o_res   | out | float_bits, bad_scale
//
//  One request enters per cycle unless a stall holds the pipe; there are 2 normalize
//  stages, 26 quotient-bit stages of the restoring divider and 1 round/output stage.
//  Each stage holds only when it is full and the stage after it is held,
//  so bubbles close up under a stall.
//  Reset clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
`include "scaled_decimal_to_float32_macros.svh"

module scaled_decimal_to_float32 (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sdf_in_if.sink    i_req,
    sdf_out_if.source o_res
);

    localparam int unsigned Steps = sdf_pkg::QuoW;

    sdf_pkg::t_in  w_in;
    sdf_pkg::t_div w_d   [0:Steps];
    logic          w_vld [0:Steps];
    logic          w_rdy [0:Steps];
    sdf_pkg::t_res w_res;

    assign w_in.mant  = {i_req.mant_high, i_req.mant_mid, i_req.mant_low};
    assign w_in.scale = i_req.scale;
    assign w_in.neg   = i_req.negative;

    sdf_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_req.valid),
        .o_rdy   (i_req.ready),
        .i_data  (w_in),
        .o_vld   (w_vld[0]),
        .i_rdy   (w_rdy[0]),
        .o_data  (w_d[0])
    );

    for (genvar g = 0; g < Steps; g++) begin : g_step
        sdf_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .i_data  (w_d[g]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1]),
            .o_data  (w_d[g+1])
        );
    end

    sdf_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[Steps]),
        .o_rdy   (w_rdy[Steps]),
        .i_data  (w_d[Steps]),
        .o_vld   (o_res.valid),
        .i_rdy   (o_res.ready),
        .o_data  (w_res)
    );

    assign o_res.float_bits = w_res.float_bits;
    assign o_res.bad_scale  = w_res.bad_scale;

    `SDF_ASSERT_NOW(a_bad_zero, o_res.valid && o_res.bad_scale, o_res.float_bits[30:0] == 31'd0, "bad scale result is not a signed zero")
    `SDF_ASSERT_NOW(a_norm_exp, o_res.valid && (o_res.float_bits[30:0] != 31'd0), o_res.float_bits[30:23] != 8'd0 && o_res.float_bits[30:23] != 8'hFF, "result is not a normal number")
    `SDF_ASSERT_NEXT(a_accept, i_req.valid && i_req.ready, u_norm.r_vld1, "accepted request not captured")
    `SDF_ASSERT_NOW(a_quo_lead, w_vld[Steps] && !w_d[Steps].bad && !w_d[Steps].zero, w_d[Steps].quo[Steps-1] || w_d[Steps].quo[Steps-2], "quotient lacks a leading one")

endmodule
